// File: rtl/core/fixed_partition_fit_allocator_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fixed-partition fit allocator
// Shared forms for immediate-cycle and next-cycle implications.
// ----------------------------------------------------------------------------
`ifndef FIXED_PARTITION_FIT_ALLOCATOR_TOP_MACROS_SVH
`define FIXED_PARTITION_FIT_ALLOCATOR_TOP_MACROS_SVH

// check cons in the same cycle as ante
`define FPFA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// check cons in the cycle after ante
`define FPFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/fpfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-partition fit allocator package
// Sizes, codes and beat types shared by the allocator.
// ----------------------------------------------------------------------------
package fpfa_pkg;

  localparam int NUM_PARTITIONS = 16;
  localparam int SIZE_BITS      = 16;

  localparam int IDX_BITS = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
  localparam int LIM_W    = $clog2(NUM_PARTITIONS + 1);

  localparam int OP_W     = 2;
  localparam int BIDX_W   = 4;
  localparam int REQ_W    = 16;
  localparam int STAT_W   = 2;
  localparam int GIDX_W   = 4;
  localparam int TOT_W    = 16;
  localparam int MODE_W   = 2;
  localparam int BCNT_W   = 5;
  localparam int CFG_W    = 5;
  localparam int WIDE_W   = (SIZE_BITS > REQ_W) ? SIZE_BITS : REQ_W;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_GRANT = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOFIT = 2'd2;

  localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

  localparam logic REG_FIT_MODE    = 1'b0;
  localparam logic REG_BLOCK_COUNT = 1'b1;

  localparam logic [BCNT_W-1:0] BLOCK_COUNT_RST = 5'd16;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BIDX_W-1:0] block_index;
    logic [REQ_W-1:0]  request_size;
  } in_beat_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [GIDX_W-1:0] granted_index;
    logic [TOT_W-1:0]  granted_total;
    logic [TOT_W-1:0]  leftover;
  } out_beat_t;

endpackage

// File: rtl/core/fixed_partition_fit_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-partition fit allocator
// Keeps partition sizes in a synchronous memory and taken flags in
// flip-flops; grants partitions by first, best or worst fit.
// ----------------------------------------------------------------------------
// A beat is taken when start is high and busy is low. Every beat gives one
// result, shown on out_data for exactly one cycle while out_strobe is high;
// the receiver cannot stall it, so it must take each result as it appears.
// Load, clear and undefined ops show their result in the cycle after they
// are taken and leave busy low; an allocate with block_count zero reports
// no fit the same way. Any other allocate scans the size memory one
// partition per cycle through its single read port: busy stays high
// through the scan, drain and report states, and the result is shown in
// the first cycle after busy falls. A new beat may be taken in the cycle
// the previous result is shown. Partition sizes have no reset; allocating
// over a partition that was never loaded gives an undefined choice.
// ----------------------------------------------------------------------------
`include "fixed_partition_fit_allocator_top_macros.svh"

module fixed_partition_fit_allocator_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  fpfa_pkg::in_beat_t              in_data,
  output logic                            out_strobe,
  output fpfa_pkg::out_beat_t             out_data,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [fpfa_pkg::CFG_W-1:0]      cfg_wdata
);
  import fpfa_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_REPORT
  } state_t;

  state_t               state_r;
  logic [MODE_W-1:0]    fit_mode_r;
  logic [BCNT_W-1:0]    block_count_r;
  logic [NUM_PARTITIONS-1:0] taken_r;
  logic [SIZE_BITS-1:0] size_mem [NUM_PARTITIONS];
  logic [SIZE_BITS-1:0] rd_data_r;
  logic [LIM_W-1:0]     cnt_r;
  logic [LIM_W-1:0]     limit_r;
  logic [REQ_W-1:0]     req_r;
  logic                 cmp_vld_r;
  logic [IDX_BITS-1:0]  cmp_idx_r;
  logic                 have_r;
  logic [IDX_BITS-1:0]  found_r;
  logic [SIZE_BITS-1:0] best_left_r;
  logic [SIZE_BITS-1:0] best_total_r;
  logic                 out_strobe_r;
  out_beat_t            out_data_r;

  state_t               state_nxt;
  logic [NUM_PARTITIONS-1:0] taken_nxt;
  logic [LIM_W-1:0]     cnt_nxt;
  logic [LIM_W-1:0]     limit_nxt;
  logic [REQ_W-1:0]     req_nxt;
  logic                 cmp_vld_nxt;
  logic [IDX_BITS-1:0]  cmp_idx_nxt;
  logic                 have_nxt;
  logic [IDX_BITS-1:0]  found_nxt;
  logic [SIZE_BITS-1:0] best_left_nxt;
  logic [SIZE_BITS-1:0] best_total_nxt;
  logic                 out_strobe_nxt;
  out_beat_t            out_data_nxt;

  logic                 accept;
  logic                 load_ok;
  logic                 mem_we;
  logic [IDX_BITS-1:0]  wr_addr;
  logic [IDX_BITS-1:0]  rd_addr;
  logic [LIM_W-1:0]     limit;
  logic                 fits;
  logic                 take;
  logic [SIZE_BITS-1:0] cmp_left;
  logic                 last_issue;

  assign busy       = (state_r != ST_IDLE);
  assign accept     = start && !busy;
  assign load_ok    = (32'(in_data.block_index) < 32'(NUM_PARTITIONS));
  assign mem_we     = accept && (in_data.op == OP_LOAD) && load_ok;
  assign wr_addr    = IDX_BITS'(in_data.block_index);
  assign rd_addr    = cnt_r[IDX_BITS-1:0];
  assign last_issue = (cnt_r == LIM_W'(limit_r - 1'b1));
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  always_comb begin
    if (32'(block_count_r) > 32'(NUM_PARTITIONS)) begin
      limit = LIM_W'(NUM_PARTITIONS);
    end else begin
      limit = LIM_W'(block_count_r);
    end
  end

  always_comb begin
    fits     = cmp_vld_r && !taken_r[cmp_idx_r] &&
               (WIDE_W'(rd_data_r) >= WIDE_W'(req_r));
    cmp_left = rd_data_r - SIZE_BITS'(req_r);
    take     = fits && (!have_r ||
                        ((fit_mode_r == MODE_BEST) && (cmp_left < best_left_r)) ||
                        ((fit_mode_r == MODE_WORST) && (cmp_left > best_left_r)));
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      size_mem[wr_addr] <= SIZE_BITS'(in_data.request_size);
    end
    rd_data_r <= size_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r    <= MODE_FIRST;
      block_count_r <= BLOCK_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FIT_MODE:    fit_mode_r    <= cfg_wdata[MODE_W-1:0];
        REG_BLOCK_COUNT: block_count_r <= cfg_wdata[BCNT_W-1:0];
        default:         fit_mode_r    <= fit_mode_r;
      endcase
    end
  end

  always_comb begin
    state_nxt      = state_r;
    taken_nxt      = taken_r;
    cnt_nxt        = cnt_r;
    limit_nxt      = limit_r;
    req_nxt        = req_r;
    cmp_vld_nxt    = cmp_vld_r;
    cmp_idx_nxt    = cmp_idx_r;
    have_nxt       = have_r;
    found_nxt      = found_r;
    best_left_nxt  = best_left_r;
    best_total_nxt = best_total_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;
    if (take) begin
      have_nxt       = 1'b1;
      found_nxt      = cmp_idx_r;
      best_left_nxt  = cmp_left;
      best_total_nxt = rd_data_r;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_strobe_nxt      = 1'b1;
          out_data_nxt        = '0;
          out_data_nxt.status = STAT_DONE;
          unique case (in_data.op)
            OP_LOAD: begin
              if (load_ok) begin
                taken_nxt[wr_addr] = 1'b0;
              end
            end
            OP_ALLOC: begin
              if (limit == '0) begin
                out_data_nxt.status = STAT_NOFIT;
              end else begin
                out_strobe_nxt = 1'b0;
                state_nxt      = ST_SCAN;
                cnt_nxt        = '0;
                limit_nxt      = limit;
                req_nxt        = in_data.request_size;
                have_nxt       = 1'b0;
              end
            end
            OP_CLEAR: taken_nxt = '0;
            default:  taken_nxt = taken_r;
          endcase
        end
      end
      ST_SCAN: begin
        cmp_vld_nxt = 1'b1;
        cmp_idx_nxt = rd_addr;
        cnt_nxt     = LIM_W'(cnt_r + 1'b1);
        if (last_issue) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cmp_vld_nxt = 1'b0;
        state_nxt   = ST_REPORT;
      end
      ST_REPORT: begin
        out_strobe_nxt = 1'b1;
        if (have_r) begin
          taken_nxt[found_r]         = 1'b1;
          out_data_nxt.status        = STAT_GRANT;
          out_data_nxt.granted_index = GIDX_W'(found_r);
          out_data_nxt.granted_total = TOT_W'(best_total_r);
          out_data_nxt.leftover      = TOT_W'(best_left_r);
        end else begin
          out_data_nxt        = '0;
          out_data_nxt.status = STAT_NOFIT;
        end
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      taken_r      <= '0;
      cmp_vld_r    <= 1'b0;
      have_r       <= 1'b0;
      out_strobe_r <= 1'b0;
      out_data_r   <= '0;
      cnt_r        <= '0;
      limit_r      <= '0;
      req_r        <= '0;
      cmp_idx_r    <= '0;
      found_r      <= '0;
      best_left_r  <= '0;
      best_total_r <= '0;
    end else begin
      state_r      <= state_nxt;
      taken_r      <= taken_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      have_r       <= have_nxt;
      out_strobe_r <= out_strobe_nxt;
      out_data_r   <= out_data_nxt;
      cnt_r        <= cnt_nxt;
      limit_r      <= limit_nxt;
      req_r        <= req_nxt;
      cmp_idx_r    <= cmp_idx_nxt;
      found_r      <= found_nxt;
      best_left_r  <= best_left_nxt;
      best_total_r <= best_total_nxt;
    end
  end

  `FPFA_ASSERT_SAME(a_grant_marks_taken,
    out_strobe_r && (out_data_r.status == STAT_GRANT), taken_r[found_r],
    "granted partition not marked taken")
  `FPFA_ASSERT_SAME(a_no_strobe_while_busy, state_r != ST_IDLE, !out_strobe_r,
    "result shown while scan in progress")
  `FPFA_ASSERT_SAME(a_zero_fields_unless_grant,
    out_strobe_r && (out_data_r.status != STAT_GRANT),
    (out_data_r.granted_index == '0) && (out_data_r.granted_total == '0) &&
    (out_data_r.leftover == '0),
    "non-grant result carries grant fields")
  `FPFA_ASSERT_SAME(a_scan_in_range, state_r == ST_SCAN, cnt_r < limit_r,
    "scan index beyond partition limit")

endmodule

// File: tb/fpfa_reply_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator reply checker
// Keeps its own copy of the partition table and the fit settings. It
// predicts one reply for each accepted beat and compares every strobed
// reply, field by field, with the oldest reply still due.
// ----------------------------------------------------------------------------
module fpfa_reply_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  fpfa_pkg::in_beat_t         in_data,
  input  logic                       out_strobe,
  input  fpfa_pkg::out_beat_t        out_data,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [fpfa_pkg::CFG_W-1:0] cfg_wdata,
  output int                         errors,
  output int                         outstanding
);
  import fpfa_pkg::*;

  logic [SIZE_BITS-1:0] part_size [NUM_PARTITIONS];
  logic                 part_taken [NUM_PARTITIONS];
  logic [MODE_W-1:0]    mode_q;
  logic [BCNT_W-1:0]    count_q;
  out_beat_t            replies_due [$];
  out_beat_t            want;

  function automatic out_beat_t apply_beat(in_beat_t b);
    out_beat_t            r;
    int                   limit;
    int                   found;
    logic [SIZE_BITS-1:0] best_left;
    logic [SIZE_BITS-1:0] left;
    bit                   have;
    bit                   stop;
    r = '0;
    r.status = STAT_DONE;
    case (b.op)
      OP_LOAD: begin
        part_size[b.block_index]  = b.request_size;
        part_taken[b.block_index] = 1'b0;
      end
      OP_CLEAR: begin
        for (int i = 0; i < NUM_PARTITIONS; i++) part_taken[i] = 1'b0;
      end
      OP_ALLOC: begin
        limit     = (int'(count_q) > NUM_PARTITIONS) ? NUM_PARTITIONS : int'(count_q);
        have      = 1'b0;
        stop      = 1'b0;
        found     = 0;
        best_left = '0;
        for (int i = 0; i < limit && !stop; i++) begin
          if (!part_taken[i] && part_size[i] >= b.request_size) begin
            left = part_size[i] - b.request_size;
            if (!have) begin
              have      = 1'b1;
              found     = i;
              best_left = left;
              // first fit, and the undefined mode, stop at the lowest match
              stop = (mode_q != MODE_BEST) && (mode_q != MODE_WORST);
            end else if (mode_q == MODE_BEST && left < best_left) begin
              found     = i;
              best_left = left;
            end else if (mode_q == MODE_WORST && left > best_left) begin
              found     = i;
              best_left = left;
            end
          end
        end
        if (have) begin
          part_taken[found] = 1'b1;
          r.status          = STAT_GRANT;
          r.granted_index   = found[GIDX_W-1:0];
          r.granted_total   = part_size[found];
          r.leftover        = best_left;
        end else begin
          r.status = STAT_NOFIT;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PARTITIONS; i++) begin
        part_size[i]  = '0;
        part_taken[i] = 1'b0;
      end
      mode_q  = MODE_FIRST;
      count_q = BLOCK_COUNT_RST;
      replies_due.delete();
      outstanding = 0;
    end else begin
      if (out_strobe) begin
        if (replies_due.size() == 0) begin
          errors = errors + 1;
          if (errors <= 10)
            $display("%0t checker: reply with none due: %0d/%0d/%0d/%0d",
                     $time, out_data.status, out_data.granted_index,
                     out_data.granted_total, out_data.leftover);
        end else begin
          want = replies_due.pop_front();
          if (out_data !== want) begin
            errors = errors + 1;
            if (errors <= 10)
              $display("%0t checker: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                       $time, want.status, want.granted_index, want.granted_total,
                       want.leftover, out_data.status, out_data.granted_index,
                       out_data.granted_total, out_data.leftover);
          end
        end
      end
      if (start && !busy) replies_due.push_back(apply_beat(in_data));
      if (cfg_we) begin
        if (cfg_index == REG_FIT_MODE) mode_q = cfg_wdata[MODE_W-1:0];
        else count_q = cfg_wdata[BCNT_W-1:0];
      end
      outstanding = replies_due.size();
    end
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-partition fit allocator testbench
// Drives directed and random load, allocate, clear and undefined beats under
// several fit settings and sender gaps; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  import fpfa_pkg::*;

  localparam int              CYCLE_LIMIT = 500000;
  localparam int              IN_W        = $bits(in_beat_t);
  localparam logic [OP_W-1:0]   OP_UNDEF   = 2'd3;
  localparam logic [MODE_W-1:0] MODE_UNDEF = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  in_beat_t             in_data;
  logic                 out_strobe;
  out_beat_t            out_data;
  logic                 cfg_we;
  logic                 cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  int                   errors;
  int                   outstanding;
  int                   cycles = 0;
  int                   idle_pct;
  logic [NUM_PARTITIONS-1:0] loaded;
  logic [BCNT_W-1:0]    count_now;

  fixed_partition_fit_allocator_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  fpfa_reply_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_data     (in_data),
    .out_strobe  (out_strobe),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  function automatic in_beat_t mk(logic [OP_W-1:0] op, logic [BIDX_W-1:0] idx,
                                  logic [REQ_W-1:0] size);
    in_beat_t b;
    b.op           = op;
    b.block_index  = idx;
    b.request_size = size;
    return b;
  endfunction

  // lowest partition in range that was never loaded, or -1
  function automatic int first_gap();
    int limit;
    limit = (int'(count_now) > NUM_PARTITIONS) ? NUM_PARTITIONS : int'(count_now);
    for (int i = 0; i < limit; i++)
      if (!loaded[i]) return i;
    return -1;
  endfunction

  function automatic logic [REQ_W-1:0] pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 70) return REQ_W'($urandom_range(400));
    if (r < 88) return REQ_W'($urandom);
    if (r < 94) return '0;
    return '1;
  endfunction

  function automatic in_beat_t random_beat();
    in_beat_t b;
    int       r;
    int       gap;
    b = IN_W'($urandom);
    b.request_size = pick_size();
    r = $urandom_range(99);
    if (r < 16) b.op = OP_LOAD;
    else if (r < 88) b.op = OP_ALLOC;
    else if (r < 94) b.op = OP_CLEAR;
    else b.op = OP_UNDEF;
    if (b.op == OP_ALLOC) begin
      gap = first_gap();
      // fill an unloaded partition before any allocate may scan it
      if (gap >= 0) begin
        b.op          = OP_LOAD;
        b.block_index = gap[BIDX_W-1:0];
      end
    end
    return b;
  endfunction

  task automatic send(in_beat_t b);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start   <= 1'b0;
      in_data <= IN_W'($urandom);
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= b;
    if (b.op == OP_LOAD) loaded[b.block_index] = 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (outstanding != 0 || busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic set_config(logic [MODE_W-1:0] mode, logic [BCNT_W-1:0] cnt);
    logic [CFG_W-1:0] w;
    w = CFG_W'($urandom);
    w[MODE_W-1:0] = mode;
    cfg_we    <= 1'b1;
    cfg_index <= REG_FIT_MODE;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= REG_BLOCK_COUNT;
    cfg_wdata <= cnt;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cfg_wdata <= CFG_W'($urandom);
    count_now = cnt;
  endtask

  initial begin
    logic [MODE_W-1:0] mode;
    logic [BCNT_W-1:0] cnt;
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_FIT_MODE;
    cfg_wdata <= '0;
    loaded    = '0;
    count_now = BLOCK_COUNT_RST;
    idle_pct  = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_config(MODE_FIRST, 5'd4);
    send(mk(OP_LOAD, 4'd0, 16'd100));
    send(mk(OP_LOAD, 4'd1, 16'hFFFF));
    send(mk(OP_LOAD, 4'd2, 16'd100));
    send(mk(OP_LOAD, 4'd3, 16'd0));
    send(mk(OP_ALLOC, 4'd15, 16'd0));
    send(mk(OP_ALLOC, 4'd0, 16'd100));
    send(mk(OP_ALLOC, 4'd0, 16'hFFFF));
    send(mk(OP_UNDEF, 4'd15, 16'hFFFF));
    send(mk(OP_CLEAR, 4'd15, 16'hFFFF));
    drain();
    set_config(MODE_BEST, 5'd4);
    send(mk(OP_ALLOC, 4'd0, 16'd100));
    send(mk(OP_ALLOC, 4'd0, 16'd100));
    send(mk(OP_ALLOC, 4'd0, 16'd0));
    send(mk(OP_ALLOC, 4'd0, 16'd0));
    send(mk(OP_ALLOC, 4'd0, 16'd0));
    send(mk(OP_CLEAR, 4'd0, 16'd0));
    drain();
    set_config(MODE_WORST, 5'd4);
    send(mk(OP_ALLOC, 4'd0, 16'd0));
    send(mk(OP_ALLOC, 4'd0, 16'd50));
    send(mk(OP_ALLOC, 4'd0, 16'hFFFF));
    drain();
    set_config(MODE_UNDEF, 5'd4);
    send(mk(OP_CLEAR, 4'd0, 16'd0));
    send(mk(OP_ALLOC, 4'd0, 16'd0));
    drain();
    set_config(MODE_FIRST, 5'd0);
    send(mk(OP_ALLOC, 4'd0, 16'd0));
    send(mk(OP_LOAD, 4'd15, 16'hFFFF));

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       idle_pct = 20;
        1:       idle_pct = 58;
        default: idle_pct = 0;
      endcase
      for (int seg = 0; seg < 5; seg++) begin
        mode = MODE_W'((phase + seg) % 4);
        if (seg == 0) begin
          case (phase)
            0:       cnt = 5'd1;
            1:       cnt = 5'd31;
            default: cnt = 5'd16;
          endcase
        end else if ($urandom_range(1) == 0) begin
          cnt = BCNT_W'($urandom_range(16, 1));
        end else begin
          cnt = BCNT_W'($urandom_range(31));
        end
        drain();
        set_config(mode, cnt);
        repeat (63) begin
          if ($urandom_range(99) == 0) drain();
          send(random_beat());
        end
      end
    end

    drain();
    repeat (30) @(posedge clk);
    if (errors == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/fpfa_pkg.sv
rtl/core/fixed_partition_fit_allocator_top.sv
tb/fpfa_reply_checker.sv
tb/tb_top.sv
